// ===== design/swv_pkg.sv =====
// Shared types and constants for the two-wheel swerve odometry unit.
// Used by the wheel lanes, the divider, the merge stage and the top level.
package swv_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int CRD_W        = 34;
    localparam int TRIG_W       = 18;
    localparam int VEL_W        = 34;
    localparam int SUM_W        = 35;
    localparam int DVD_W        = 34;
    localparam int DEN_W        = 16;
    localparam int POS_W        = 12;
    localparam int ACC_W        = 50;

    localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sd652032874;

    localparam logic signed [CRD_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
        34'sd21354465,  34'sd10679838,  34'sd5340245,   34'sd2670163,  34'sd1335087,
        34'sd667544,    34'sd333772,    34'sd166886,    34'sd83443,    34'sd41722,
        34'sd20861,     34'sd10430,     34'sd5215,      34'sd2608,     34'sd1304
    };

    localparam logic [1:0] CFG_WHEEL_A_X = 2'd0;
    localparam logic [1:0] CFG_WHEEL_A_Y = 2'd1;
    localparam logic [1:0] CFG_WHEEL_B_X = 2'd2;
    localparam logic [1:0] CFG_WHEEL_B_Y = 2'd3;

    typedef struct packed {
        logic                    neg;
        logic                    sel_x;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] res_base;
    } swv_tag_t;

endpackage

// ===== design/two_wheel_swerve_odometry_unit.sv =====
// Throughput: one word per cycle; every stage is a register and the pipeline moves
// whenever the output register is empty or being taken.
// Depth is set by the 20-stage CORDIC lanes and the 34-stage bit-per-stage divider.
// Reset (aresetn low, synchronous) empties the pipeline and loads the default
// wheel positions; configuration writes are taken in any cycle.
module two_wheel_swerve_odometry_unit #(
    parameter int ANGLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_speed_a,
    input  logic        [15:0] s_angle_a,
    input  logic signed [15:0] s_speed_b,
    input  logic        [15:0] s_angle_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [17:0] m_body_vx,
    output logic signed [17:0] m_body_vy,
    output logic signed [31:0] m_yaw_rate,
    output logic        [16:0] m_slippage,
    output logic               m_degenerate
);
    import swv_pkg::*;

    logic signed [POS_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic                    en;
    logic                    va_valid, vb_valid;
    logic signed [VEL_W-1:0] v1x, v1y, v2x, v2y;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_reg <= 12'sd0;
            ay_reg <= 12'sd155;
            bx_reg <= 12'sd0;
            by_reg <= -12'sd155;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WHEEL_A_X: ax_reg <= cfg_data;
                CFG_WHEEL_A_Y: ay_reg <= cfg_data;
                CFG_WHEEL_B_X: bx_reg <= cfg_data;
                CFG_WHEEL_B_Y: by_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    swv_wheel_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .speed     (s_speed_a),
        .angle     (s_angle_a),
        .out_valid (va_valid),
        .vel_x     (v1x),
        .vel_y     (v1y)
    );

    swv_wheel_lane #(.ANGLE_BITS(ANGLE_BITS)) u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .speed     (s_speed_b),
        .angle     (s_angle_b),
        .out_valid (vb_valid),
        .vel_x     (v2x),
        .vel_y     (v2y)
    );

    swv_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (va_valid && vb_valid),
        .v1x        (v1x),
        .v1y        (v1y),
        .v2x        (v2x),
        .v2y        (v2y),
        .ax         (ax_reg),
        .ay         (ay_reg),
        .bx         (bx_reg),
        .by         (by_reg),
        .out_valid  (m_valid),
        .body_vx    (m_body_vx),
        .body_vy    (m_body_vy),
        .yaw_rate   (m_yaw_rate),
        .slippage   (m_slippage),
        .degenerate (m_degenerate)
    );

endmodule

// ===== design/swv_wheel_lane.sv =====
// One wheel lane: pipelined CORDIC cos/sin and the speed multiply.
// Depends on swv_pkg.
module swv_wheel_lane #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [15:0]               speed,
    input  logic        [15:0]               angle,
    output logic                             out_valid,
    output logic signed [swv_pkg::VEL_W-1:0] vel_x,
    output logic signed [swv_pkg::VEL_W-1:0] vel_y
);
    import swv_pkg::*;

    localparam int ASHIFT = 32 - ANGLE_BITS;
    localparam logic [39:0] AMASK = (40'd1 << ANGLE_BITS) - 40'd1;

    logic [39:0] ang_ext;
    logic [31:0] ang_32;
    logic [31:0] ang_adj;
    logic        flip_in;

    logic signed [CRD_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CRD_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CRD_W-1:0] z_reg [0:CORDIC_STEPS];
    logic                    flip_reg [0:CORDIC_STEPS];
    logic signed [15:0]      spd_reg [0:CORDIC_STEPS];
    logic                    vld_reg [0:CORDIC_STEPS];

    logic signed [CRD_W-1:0]  xr, yr;
    logic signed [TRIG_W-1:0] cos_next, sin_next;
    logic signed [TRIG_W-1:0] cos_reg, sin_reg;
    logic signed [15:0]       spd_rnd_reg;
    logic                     vld_rnd_reg;
    logic signed [VEL_W-1:0]  vx_reg, vy_reg;
    logic                     vld_mul_reg;

    assign ang_ext = 40'(angle) & AMASK;
    assign ang_32  = 32'(ang_ext << ASHIFT);
    assign flip_in = ang_32[31] ^ ang_32[30];
    assign ang_adj = {ang_32[31] ^ flip_in, ang_32[30:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= CRD_W'($signed(ang_adj));
            flip_reg[0] <= flip_in;
            spd_reg[0]  <= speed;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][CRD_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                flip_reg[i+1] <= flip_reg[i];
                spd_reg[i+1]  <= spd_reg[i];
            end
        end
    end

    always_comb begin
        xr = (x_reg[CORDIC_STEPS] + CRD_W'(8192)) >>> 14;
        yr = (y_reg[CORDIC_STEPS] + CRD_W'(8192)) >>> 14;
        if (xr > CRD_W'(65536)) begin
            cos_next = TRIG_W'(65536);
        end else if (xr < -CRD_W'(65536)) begin
            cos_next = -TRIG_W'(65536);
        end else begin
            cos_next = TRIG_W'(xr);
        end
        if (yr > CRD_W'(65536)) begin
            sin_next = TRIG_W'(65536);
        end else if (yr < -CRD_W'(65536)) begin
            sin_next = -TRIG_W'(65536);
        end else begin
            sin_next = TRIG_W'(yr);
        end
        if (flip_reg[CORDIC_STEPS]) begin
            cos_next = -cos_next;
            sin_next = -sin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_rnd_reg <= 1'b0;
            vld_mul_reg <= 1'b0;
        end else if (en) begin
            vld_rnd_reg <= vld_reg[CORDIC_STEPS];
            vld_mul_reg <= vld_rnd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            spd_rnd_reg <= spd_reg[CORDIC_STEPS];
            vx_reg      <= VEL_W'(spd_rnd_reg) * VEL_W'(cos_reg);
            vy_reg      <= VEL_W'(spd_rnd_reg) * VEL_W'(sin_reg);
        end
    end

    assign out_valid = vld_mul_reg;
    assign vel_x     = vx_reg;
    assign vel_y     = vy_reg;

endmodule

// ===== design/swv_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side-band tag.
// Depends on swv_pkg.
module swv_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [swv_pkg::DVD_W-1:0] in_dvd,
    input  logic [swv_pkg::DEN_W-1:0] in_den,
    input  swv_pkg::swv_tag_t         in_tag,
    output logic                      out_valid,
    output logic [swv_pkg::DVD_W-1:0] out_quo,
    output swv_pkg::swv_tag_t         out_tag
);
    import swv_pkg::*;

    logic [DEN_W-1:0] rem_st [0:DVD_W];
    logic [DVD_W-1:0] dvd_st [0:DVD_W];
    logic [DVD_W-1:0] quo_st [0:DVD_W];
    logic [DEN_W-1:0] den_st [0:DVD_W];
    swv_tag_t         tag_st [0:DVD_W];
    logic             vld_st [0:DVD_W];

    assign rem_st[0] = '0;
    assign dvd_st[0] = in_dvd;
    assign quo_st[0] = '0;
    assign den_st[0] = in_den;
    assign tag_st[0] = in_tag;
    assign vld_st[0] = in_valid;

    for (genvar k = 0; k < DVD_W; k++) begin : g_bit
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           take;
        logic [DEN_W-1:0] rem_reg;
        logic [DVD_W-1:0] dvd_reg;
        logic [DVD_W-1:0] quo_reg;
        logic [DEN_W-1:0] den_reg;
        swv_tag_t         tag_reg;
        logic             vld_reg;

        assign trial = {rem_st[k], dvd_st[k][DVD_W-1]};
        assign take  = trial >= {1'b0, den_st[k]};
        assign diff  = trial - {1'b0, den_st[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_st[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg <= take ? DEN_W'(diff) : DEN_W'(trial);
                dvd_reg <= {dvd_st[k][DVD_W-2:0], 1'b0};
                quo_reg <= {quo_st[k][DVD_W-2:0], take};
                den_reg <= den_st[k];
                tag_reg <= tag_st[k];
            end
        end

        assign rem_st[k+1] = rem_reg;
        assign dvd_st[k+1] = dvd_reg;
        assign quo_st[k+1] = quo_reg;
        assign den_st[k+1] = den_reg;
        assign tag_st[k+1] = tag_reg;
        assign vld_st[k+1] = vld_reg;
    end

    assign out_valid = vld_st[DVD_W];
    assign out_quo   = quo_st[DVD_W];
    assign out_tag   = tag_st[DVD_W];

endmodule

// ===== design/swv_merge.sv =====
// Merge stage: wheel vectors to yaw rate, body velocity, slippage and degenerate.
// Depends on swv_pkg and swv_divider.
module swv_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [swv_pkg::VEL_W-1:0]  v1x,
    input  logic signed [swv_pkg::VEL_W-1:0]  v1y,
    input  logic signed [swv_pkg::VEL_W-1:0]  v2x,
    input  logic signed [swv_pkg::VEL_W-1:0]  v2y,
    input  logic signed [swv_pkg::POS_W-1:0]  ax,
    input  logic signed [swv_pkg::POS_W-1:0]  ay,
    input  logic signed [swv_pkg::POS_W-1:0]  bx,
    input  logic signed [swv_pkg::POS_W-1:0]  by,
    output logic                              out_valid,
    output logic signed [17:0]                body_vx,
    output logic signed [17:0]                body_vy,
    output logic signed [31:0]                yaw_rate,
    output logic        [16:0]                slippage,
    output logic                              degenerate
);
    import swv_pkg::*;

    logic signed [12:0]      dx, dy, sum_ay, sum_ax;
    logic [11:0]             adx, ady;
    logic                    sel_x;
    logic signed [SUM_W-1:0] num;
    logic [DVD_W-1:0]        num_mag;
    logic [DEN_W-1:0]        den;
    swv_tag_t                tag_next;

    logic [DVD_W-1:0] dvd_reg;
    logic [DEN_W-1:0] den_reg;
    swv_tag_t         tag_reg;
    logic             vld0_reg;

    logic             div_valid;
    logic [DVD_W-1:0] div_quo;
    swv_tag_t         div_tag;

    logic signed [31:0] yaw_next;
    logic signed [31:0] yaw1_reg, yaw2_reg;
    logic signed [44:0] pa_reg, pb_reg, pc_reg;
    swv_tag_t           tag1_reg;
    logic               vld1_reg;

    logic signed [ACC_W-1:0] nx, ny, nr;
    logic [ACC_W-2:0]        mx_reg, my_reg, mr_reg;
    logic                    sx_reg, sy_reg;
    logic                    vld2_reg;

    logic [ACC_W-2:0]   qx, qy, qr;
    logic signed [17:0] vx_next, vy_next;
    logic [16:0]        slip_next;
    logic               deg;

    logic signed [17:0] vx_reg, vy_reg;
    logic signed [31:0] yaw_reg;
    logic [16:0]        slip_reg;
    logic               deg_reg;
    logic               vld3_reg;

    always_comb begin
        dx     = 13'(bx) - 13'(ax);
        dy     = 13'(by) - 13'(ay);
        adx    = 12'(dx[12] ? -dx : dx);
        ady    = 12'(dy[12] ? -dy : dy);
        sel_x  = adx > ady;
        num    = sel_x ? (SUM_W'(v2y) - SUM_W'(v1y)) : (SUM_W'(v1x) - SUM_W'(v2x));
        num_mag = DVD_W'(num[SUM_W-1] ? -num : num);
        den    = {(sel_x ? adx : ady), 4'b0000};
        tag_next.neg      = num[SUM_W-1] ^ (sel_x ? dx[12] : dy[12]);
        tag_next.sel_x    = sel_x;
        tag_next.sum_x    = SUM_W'(v1x) + SUM_W'(v2x);
        tag_next.sum_y    = SUM_W'(v1y) + SUM_W'(v2y);
        tag_next.res_base = sel_x ? (SUM_W'(v1x) - SUM_W'(v2x))
                                  : (SUM_W'(v2y) - SUM_W'(v1y));
        sum_ay = 13'(ay) + 13'(by);
        sum_ax = 13'(ax) + 13'(bx);
        deg    = (dx == '0) && (dy == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= in_valid;
            vld1_reg <= div_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg <= num_mag + DVD_W'(den >> 1);
            den_reg <= den;
            tag_reg <= tag_next;
        end
    end

    swv_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld0_reg),
        .in_dvd    (dvd_reg),
        .in_den    (den_reg),
        .in_tag    (tag_reg),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_tag   (div_tag)
    );

    always_comb begin
        yaw_next = $signed(div_quo[31:0]);
        if (div_tag.neg) begin
            yaw_next = -yaw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw1_reg <= yaw_next;
            pa_reg   <= 45'(yaw_next) * 45'(sum_ay);
            pb_reg   <= 45'(yaw_next) * 45'(sum_ax);
            pc_reg   <= 45'(yaw_next) * 45'(div_tag.sel_x ? dy : dx);
            tag1_reg <= div_tag;
        end
    end

    always_comb begin
        nx = ACC_W'(tag1_reg.sum_x) + (ACC_W'(pa_reg) <<< 4);
        ny = ACC_W'(tag1_reg.sum_y) - (ACC_W'(pb_reg) <<< 4);
        nr = ACC_W'(tag1_reg.res_base) - (ACC_W'(pc_reg) <<< 4);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg   <= (ACC_W-1)'(nx[ACC_W-1] ? -nx : nx);
            my_reg   <= (ACC_W-1)'(ny[ACC_W-1] ? -ny : ny);
            mr_reg   <= (ACC_W-1)'(nr[ACC_W-1] ? -nr : nr);
            sx_reg   <= nx[ACC_W-1];
            sy_reg   <= ny[ACC_W-1];
            yaw2_reg <= yaw1_reg;
        end
    end

    always_comb begin
        qx = (mx_reg + (ACC_W-1)'(65536)) >> 17;
        qy = (my_reg + (ACC_W-1)'(65536)) >> 17;
        qr = (mr_reg + (ACC_W-1)'(32768)) >> 16;
        if (sx_reg) begin
            vx_next = (qx > (ACC_W-1)'(131072)) ? -18'sd131072 : -$signed(18'(qx));
        end else begin
            vx_next = (qx > (ACC_W-1)'(131071)) ? 18'sd131071 : $signed(18'(qx));
        end
        if (sy_reg) begin
            vy_next = (qy > (ACC_W-1)'(131072)) ? -18'sd131072 : -$signed(18'(qy));
        end else begin
            vy_next = (qy > (ACC_W-1)'(131071)) ? 18'sd131071 : $signed(18'(qy));
        end
        slip_next = (qr > (ACC_W-1)'(131071)) ? 17'd131071 : 17'(qr);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg   <= deg ? '0 : vx_next;
            vy_reg   <= deg ? '0 : vy_next;
            yaw_reg  <= deg ? '0 : yaw2_reg;
            slip_reg <= deg ? '0 : slip_next;
            deg_reg  <= deg;
        end
    end

    assign out_valid  = vld3_reg;
    assign body_vx    = vx_reg;
    assign body_vy    = vy_reg;
    assign yaw_rate   = yaw_reg;
    assign slippage   = slip_reg;
    assign degenerate = deg_reg;

endmodule

// ===== design/swv_checker.sv =====
// Port-level checks for the swerve odometry unit, bound to the top level.
// Depends on two_wheel_swerve_odometry_unit.
module swv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [17:0] m_body_vx,
    input logic signed [17:0] m_body_vy,
    input logic signed [31:0] m_yaw_rate,
    input logic        [16:0] m_slippage,
    input logic               m_degenerate
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output space");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_body_vx == 18'sd0) && (m_body_vy == 18'sd0)
            && (m_yaw_rate == 32'sd0) && (m_slippage == 17'd0))
        else $error("degenerate word with nonzero fields");

endmodule

bind two_wheel_swerve_odometry_unit swv_checker u_chk (.*);
